/* hdl/lrufa_pkg.sv */
package lrufa_pkg;

    // defaults for the top-level parameters
    localparam int MAX_SLOTS_DEF = 16;
    localparam int TAG_BITS_DEF  = 32;
    localparam int DATA_BITS_DEF = 32;

    // fixed field widths on the ports
    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int DOUT_W    = 32;
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 5;
    localparam int STAMP_W   = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam int S_TDATA_W = KEY_W + PAYLOAD_W;
    localparam int S_TUSER_W = OP_W + 1;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_PROBE = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic present;
        logic hit;
        logic full;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

    // size register value limited to 1 .. max_slots
    function automatic int clamp_slots(logic [CFG_W-1:0] size, int max_slots);
        int n;
        n = int'(size);
        if (n < 1) begin
            n = 1;
        end
        if (n > max_slots) begin
            n = max_slots;
        end
        return n;
    endfunction

endpackage

/* hdl/lrufa_ctrl.sv */
module lrufa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lrufa_pkg::ctrl_sts_t  sts,
    output lrufa_pkg::ctrl_cmd_t  cmd
);
    import lrufa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   need_evict;

    assign need_evict = (sts.op == OP_PUT) && sts.present && !sts.hit && sts.full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (need_evict) begin
                    state_next = ST_SCAN;
                end else if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_LOOKUP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_LOOKUP: begin
                cmd.finish = !need_evict && sts.out_free;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/lrufa_datapath.sv */
module lrufa_datapath #(
    parameter int MAX_SLOTS = lrufa_pkg::MAX_SLOTS_DEF,
    parameter int TAG_BITS  = lrufa_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS = lrufa_pkg::DATA_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lrufa_pkg::CFG_W-1:0]   cfg_wr_data,
    input  lrufa_pkg::op_t                in_op,
    input  logic [lrufa_pkg::KEY_W-1:0]   in_key,
    input  logic [lrufa_pkg::PAYLOAD_W-1:0] in_payload,
    input  logic                          in_present,
    input  lrufa_pkg::ctrl_cmd_t          cmd,
    output lrufa_pkg::ctrl_sts_t          sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_hit,
    output logic [lrufa_pkg::DOUT_W-1:0]  out_data,
    output logic                          out_evicted,
    output logic [lrufa_pkg::CNT_W-1:0]   out_count
);
    import lrufa_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int N_W   = $clog2(MAX_SLOTS + 1);

    // configuration and slot state
    logic [CFG_W-1:0]     size_reg;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [N_W-1:0]       occ_reg, occ_next;
    logic [STAMP_W-1:0]   counter_reg, counter_next;
    logic [TAG_BITS-1:0]  tag_reg   [MAX_SLOTS];
    logic [DATA_BITS-1:0] data_reg  [MAX_SLOTS];
    logic [STAMP_W-1:0]   stamp_reg [MAX_SLOTS];

    // request held for the duration of the transaction
    op_t                  op_reg;
    logic [TAG_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] pay_reg;
    logic                 present_reg;

    // eviction scan
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 best_found_reg;
    logic [STAMP_W-1:0]   best_stamp_reg;
    logic                 ev_reg;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic                 o_hit_reg, o_hit_next;
    logic [DOUT_W-1:0]    o_data_reg, o_data_next;
    logic                 o_ev_reg, o_ev_next;
    logic [CNT_W-1:0]     o_cnt_reg, o_cnt_next;

    logic [N_W-1:0]       n_active;
    logic [N_W-1:0]       n_cfg;
    logic [MAX_SLOTS-1:0] act_mask, cfg_mask, match, free;
    logic [N_W-1:0]       cfg_cnt;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx, free_idx, evict_idx, wr_idx;
    logic                 scan_take, scan_last, out_free;
    logic                 stamp_we, fill_we;

    assign n_active = N_W'(clamp_slots(size_reg, MAX_SLOTS));
    assign n_cfg    = N_W'(clamp_slots(cfg_wr_data, MAX_SLOTS));

    // parallel tag compare, lowest matching and lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        cfg_cnt  = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            act_mask[i] = int'(n_active) > i;
            cfg_mask[i] = int'(n_cfg) > i;
            match[i]    = valid_reg[i] && act_mask[i] && (tag_reg[i] == key_reg);
            free[i]     = !valid_reg[i] && act_mask[i];
            if (valid_reg[i] && cfg_mask[i]) begin
                cfg_cnt = cfg_cnt + 1'b1;
            end
        end
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (free[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any   = |match;
    assign out_free  = !m_valid_reg || out_ready;
    assign scan_last = int'(scan_idx_reg) == (int'(n_active) - 1);
    // strict less keeps the lower slot on equal stamps
    assign scan_take = valid_reg[scan_idx_reg]
                       && (!best_found_reg || (stamp_reg[scan_idx_reg] < best_stamp_reg));
    assign evict_idx = scan_take ? scan_idx_reg : best_idx_reg;
    assign wr_idx    = hit_any ? hit_idx : free_idx;

    assign sts.op        = op_reg;
    assign sts.present   = present_reg;
    assign sts.hit       = hit_any;
    assign sts.full      = occ_reg >= n_active;
    assign sts.scan_last = scan_last;
    assign sts.out_free  = out_free;

    always_comb begin
        valid_next   = valid_reg;
        occ_next     = occ_reg;
        counter_next = counter_reg;
        stamp_we     = 1'b0;
        fill_we      = 1'b0;
        m_valid_next = m_valid_reg && !out_ready;
        o_hit_next   = o_hit_reg;
        o_data_next  = o_data_reg;
        o_ev_next    = o_ev_reg;
        o_cnt_next   = o_cnt_reg;

        if (cmd.scan_step && scan_last) begin
            valid_next[evict_idx] = 1'b0;
            occ_next              = occ_reg - 1'b1;
        end

        if (cmd.finish) begin
            o_hit_next  = 1'b0;
            o_data_next = '0;
            o_ev_next   = 1'b0;
            unique case (op_reg)
                OP_GET: begin
                    if (hit_any) begin
                        counter_next = counter_reg + 1'b1;
                        stamp_we     = 1'b1;
                        o_hit_next   = 1'b1;
                        o_data_next  = DOUT_W'(data_reg[hit_idx]);
                    end
                end
                OP_PUT: begin
                    if (present_reg) begin
                        counter_next = counter_reg + 1'b1;
                        stamp_we     = 1'b1;
                        o_hit_next   = hit_any;
                        o_ev_next    = ev_reg;
                        if (!hit_any) begin
                            fill_we            = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            occ_next           = occ_reg + 1'b1;
                        end
                    end
                end
                OP_PROBE: begin
                    o_hit_next = hit_any;
                end
                OP_CLEAR: begin
                    valid_next = '0;
                    occ_next   = '0;
                end
                default: begin
                    o_hit_next = 1'b0;
                end
            endcase
            o_cnt_next   = CNT_W'(occ_next);
            m_valid_next = 1'b1;
        end

        // slots past the new size are dropped
        if (cfg_wr_en) begin
            valid_next = valid_reg & cfg_mask;
            occ_next   = cfg_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= CFG_RESET;
            valid_reg   <= '0;
            occ_reg     <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= in_op;
            key_reg        <= TAG_BITS'(in_key);
            pay_reg        <= DATA_BITS'(in_payload);
            present_reg    <= in_present;
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            ev_reg         <= 1'b0;
        end
        if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (scan_take) begin
                best_idx_reg   <= scan_idx_reg;
                best_stamp_reg <= stamp_reg[scan_idx_reg];
                best_found_reg <= 1'b1;
            end
            if (scan_last) begin
                ev_reg <= 1'b1;
            end
        end
        if (stamp_we) begin
            stamp_reg[wr_idx] <= counter_next;
        end
        if (fill_we) begin
            tag_reg[free_idx]  <= key_reg;
            data_reg[free_idx] <= pay_reg;
        end
        o_hit_reg  <= o_hit_next;
        o_data_reg <= o_data_next;
        o_ev_reg   <= o_ev_next;
        o_cnt_reg  <= o_cnt_next;
    end

    assign out_valid   = m_valid_reg;
    assign out_hit     = o_hit_reg;
    assign out_data    = o_data_reg;
    assign out_evicted = o_ev_reg;
    assign out_count   = o_cnt_reg;

endmodule

/* hdl/lru_fully_assoc_cache.sv */
// flow: a transaction is accepted in idle and looked up, and its result is written to the output register
//   once that register is free or being read, for get, probe, clear and put of a present key or without item
// put of a new key into a full cache adds an eviction scan of one slot per cycle over the stored stamps
//   of the active slots before the lookup is repeated and the result written
// the next transaction is taken once the last one's result is written, also while that result
//   waits; reset: aresetn synchronous active low; cache empty, counter zero, size 16
module lru_fully_assoc_cache #(
    parameter int MAX_SLOTS = lrufa_pkg::MAX_SLOTS_DEF,
    parameter int TAG_BITS  = lrufa_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS = lrufa_pkg::DATA_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // size register: number of slots in use
    input  logic                            cfg_wr_en,
    input  logic [lrufa_pkg::CFG_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrufa_pkg::S_TDATA_W-1:0] s_tdata,  // key[31:0], payload[63:32]
    input  logic [lrufa_pkg::S_TUSER_W-1:0] s_tuser,  // op[1:0], present[2]
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrufa_pkg::M_TDATA_W-1:0] m_tdata   // hit[0], data_out[32:1],
                                                      // evicted[33], occupied_count[38:34]
);
    import lrufa_pkg::*;

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    logic              out_hit;
    logic [DOUT_W-1:0] out_data;
    logic              out_evicted;
    logic [CNT_W-1:0]  out_count;

    // sequencer: accept, lookup, optional eviction scan, result
    lrufa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot storage, tag compare, stamp scan and the result register
    lrufa_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .TAG_BITS  (TAG_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_op       (op_t'(s_tuser[OP_W-1:0])),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_payload  (s_tdata[S_TDATA_W-1:KEY_W]),
        .in_present  (s_tuser[OP_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_hit     (out_hit),
        .out_data    (out_data),
        .out_evicted (out_evicted),
        .out_count   (out_count)
    );

    // result fields packed from bit 0 up, top bit padding to whole bytes
    assign m_tdata = {1'b0, out_count, out_evicted, out_data, out_hit};

endmodule
